/* rtl/phx_pkg.sv */
// ----------------------------------------------------------------------------
// phx_pkg
// shared constants, request codes and control structs of the philox generator
// ----------------------------------------------------------------------------
package phx_pkg;

  localparam int unsigned ROUNDS     = 10;
  localparam int unsigned ROUND_W    = $clog2(ROUNDS);
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned SAMPLE_W   = 23;
  localparam int unsigned SEED_W     = 64;
  localparam int unsigned CTR_W      = 4 * WORD_W;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;

  localparam logic [WORD_W-1:0] WEYL_A = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0] WEYL_B = 32'hBB67_AE85;
  localparam logic [WORD_W-1:0] MUL_A  = 32'hD251_1F53;
  localparam logic [WORD_W-1:0] MUL_B  = 32'hCD9E_8D57;

  typedef enum logic [1:0] {
    REQ_GEN     = 2'd0,
    REQ_SKIP    = 2'd1,
    REQ_RESTART = 2'd2
  } req_code_t;

  // register select bit of the apb address
  localparam int unsigned REG_SEL_BIT = 3;
  localparam logic REG_KEY    = 1'b0;
  localparam logic REG_STREAM = 1'b1;

  typedef struct packed {
    logic load_gen;
    logic round_en;
    logic emit;
    logic do_skip;
    logic do_restart;
  } phx_cmd_t;

  typedef struct packed {
    logic last_round;
    logic out_free;
  } phx_sts_t;

endpackage

/* rtl/phx_req_if.sv */
// ----------------------------------------------------------------------------
// phx_req_if
// request channel: request code and skip count
// ----------------------------------------------------------------------------
interface phx_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] skip_count;

  modport source (output valid, output req_type, output skip_count, input ready);
  modport sink   (input valid, input req_type, input skip_count, output ready);
endinterface

/* rtl/phx_smp_if.sv */
// ----------------------------------------------------------------------------
// phx_smp_if
// sample channel: four uniform fractions in units of 2^-23
// ----------------------------------------------------------------------------
interface phx_smp_if;
  logic        valid;
  logic        ready;
  logic [22:0] sample_zero;
  logic [22:0] sample_one;
  logic [22:0] sample_two;
  logic [22:0] sample_three;

  modport source (output valid, output sample_zero, output sample_one,
                  output sample_two, output sample_three, input ready);
  modport sink   (input valid, input sample_zero, input sample_one,
                  input sample_two, input sample_three, output ready);
endinterface

/* rtl/phx_cfg.sv */
// ----------------------------------------------------------------------------
// phx_cfg
// apb register file holding the key seed and the stream seed
// ----------------------------------------------------------------------------
module phx_cfg import phx_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [SEED_W-1:0]     key_seed,
  output logic [SEED_W-1:0]     stream_seed
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[REG_SEL_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_seed    <= '0;
      stream_seed <= '0;
    end else if (wr_en) begin
      if (reg_sel == REG_KEY) begin
        key_seed <= pwdata;
      end else begin
        stream_seed <= pwdata;
      end
    end
  end

  assign prdata = (reg_sel == REG_KEY) ? key_seed : stream_seed;

endmodule

/* rtl/phx_ctrl.sv */
// ----------------------------------------------------------------------------
// phx_ctrl
// request sequencer: decodes requests, steps the rounds, hands off results
// ----------------------------------------------------------------------------
module phx_ctrl import phx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] req_type,
  output logic       in_ready,
  input  phx_sts_t   sts,
  output phx_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // no item is taken while reset is held
  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_GEN: begin
              cmd.load_gen = 1'b1;
              state_next   = S_RUN;
            end
            REQ_SKIP:    cmd.do_skip    = 1'b1;
            REQ_RESTART: cmd.do_restart = 1'b1;
            default:     ;
          endcase
        end
      end
      S_RUN: begin
        cmd.round_en = 1'b1;
        if (sts.last_round) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result written into an occupied output register");

  a_gen_starts_run: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_GEN) |=> state == S_RUN)
    else $error("generate request did not start the rounds");

  a_rounds_before_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> $past(state) == S_RUN || $past(state) == S_DONE)
    else $error("result emitted without running the rounds");

endmodule

/* rtl/phx_dp.sv */
// ----------------------------------------------------------------------------
// phx_dp
// datapath: block counter, shared philox round unit, key schedule, output reg
// ----------------------------------------------------------------------------
module phx_dp import phx_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  phx_cmd_t            cmd,
  output phx_sts_t            sts,
  input  logic [SEED_W-1:0]   key_seed,
  input  logic [SEED_W-1:0]   stream_seed,
  input  logic [63:0]         skip_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] sample_zero,
  output logic [SAMPLE_W-1:0] sample_one,
  output logic [SAMPLE_W-1:0] sample_two,
  output logic [SAMPLE_W-1:0] sample_three
);

  logic [CTR_W-1:0]   counter;
  logic [CTR_W-1:0]   counter_next;
  logic [63:0]        addend;
  logic [WORD_W-1:0]  c_word [4];
  logic [WORD_W-1:0]  key0;
  logic [WORD_W-1:0]  key1;
  logic [ROUND_W-1:0] rnd_cnt;
  logic [2*WORD_W-1:0] prod0;
  logic [2*WORD_W-1:0] prod1;
  logic [WORD_W-1:0]  n_word [4];

  // one philox round
  always_comb begin
    prod0     = (2*WORD_W)'(MUL_A) * (2*WORD_W)'(c_word[0]);
    prod1     = (2*WORD_W)'(MUL_B) * (2*WORD_W)'(c_word[2]);
    n_word[0] = prod1[2*WORD_W-1:WORD_W] ^ c_word[1] ^ key0;
    n_word[1] = prod1[WORD_W-1:0];
    n_word[2] = prod0[2*WORD_W-1:WORD_W] ^ c_word[3] ^ key1;
    n_word[3] = prod0[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_gen) begin
      c_word[0] <= counter[WORD_W-1:0];
      c_word[1] <= counter[2*WORD_W-1:WORD_W];
      c_word[2] <= counter[3*WORD_W-1:2*WORD_W];
      c_word[3] <= counter[4*WORD_W-1:3*WORD_W];
      key0      <= key_seed[WORD_W-1:0];
      key1      <= key_seed[2*WORD_W-1:WORD_W];
    end else if (cmd.round_en) begin
      c_word <= n_word;
      key0   <= key0 + WEYL_A;
      key1   <= key1 + WEYL_B;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_cnt <= '0;
    end else if (cmd.load_gen) begin
      rnd_cnt <= '0;
    end else if (cmd.round_en) begin
      rnd_cnt <= rnd_cnt + ROUND_W'(1);
    end
  end

  assign sts.last_round = (rnd_cnt == ROUND_W'(ROUNDS - 1));
  assign sts.out_free   = !out_valid || out_ready;

  // counter advances by one after a generate or by the skip count
  assign addend = cmd.emit ? 64'd1 : skip_count;

  always_comb begin
    counter_next = counter;
    if (cmd.do_restart) begin
      counter_next = {stream_seed, 64'd0};
    end else if (cmd.emit || cmd.do_skip) begin
      counter_next = counter + {64'd0, addend};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else begin
      counter <= counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample_zero  <= c_word[0][SAMPLE_W-1:0];
      sample_one   <= c_word[1][SAMPLE_W-1:0];
      sample_two   <= c_word[2][SAMPLE_W-1:0];
      sample_three <= c_word[3][SAMPLE_W-1:0];
    end
  end

  a_emit_bumps_counter: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> counter == $past(counter) + CTR_W'(1))
    else $error("counter did not advance after a result");

  a_load_clears_rounds: assert property (@(posedge clk) disable iff (rst)
    cmd.load_gen |=> rnd_cnt == '0)
    else $error("round count not cleared at generate start");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("output register not marked valid after a result");

endmodule

/* rtl/philox_uniform_generator.sv */
// ----------------------------------------------------------------------------
// philox_uniform_generator
// philox4x32-10 counter based generator giving four uniform samples per item
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  req       in    valid / ready      req_type, skip_count
//  smp       out   valid / ready      sample_zero .. sample_three
//  apb       in    psel / penable     paddr, pwdata (key_seed @0, stream_seed @8)
//
//  a generate item is taken in the accept cycle, runs ten rounds through the
//  single shared round unit, then waits in hand-off for a free output register:
//  the result is registered there and the next item is taken after hand-off
//  skip, restart and unused codes finish in the accept cycle
//  a finished result sits in the output register; the next item is accepted
//  while it waits, a second result stalls in hand-off until the slot frees
//  rst is synchronous: counter, key and stream seed clear to zero, req.ready low
// ----------------------------------------------------------------------------
module philox_uniform_generator import phx_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  phx_req_if.sink               req,
  phx_smp_if.source             smp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [SEED_W-1:0] key_seed;
  logic [SEED_W-1:0] stream_seed;
  phx_cmd_t          cmd;
  phx_sts_t          sts;
  logic              in_ready;

  phx_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .key_seed    (key_seed),
    .stream_seed (stream_seed)
  );

  phx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .req_type (req.req_type),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign req.ready = in_ready;

  phx_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .key_seed     (key_seed),
    .stream_seed  (stream_seed),
    .skip_count   (req.skip_count),
    .out_valid    (smp.valid),
    .out_ready    (smp.ready),
    .sample_zero  (smp.sample_zero),
    .sample_one   (smp.sample_one),
    .sample_two   (smp.sample_two),
    .sample_three (smp.sample_three)
  );

endmodule

/* bench/philox_uniform_generator_test.sv */
// ----------------------------------------------------------------------------
// philox_uniform_generator_test
// drives generate, skip, restart and unused request codes with random gaps
// and checks every sample set against a philox4x32-10 predictor that tracks
// the block counter, key and stream seed written over the register port
// ----------------------------------------------------------------------------
module philox_uniform_generator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import phx_pkg::*;

  localparam logic [31:0] MUL_LANE0 = 32'hD251_1F53;
  localparam logic [31:0] MUL_LANE2 = 32'hCD9E_8D57;
  localparam logic [31:0] KEY_STEP0 = 32'h9E37_79B9;
  localparam logic [31:0] KEY_STEP1 = 32'hBB67_AE85;
  localparam int PHILOX_ROUND_COUNT = 10;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [APB_ADDR_W-1:0] ADDR_KEY_SEED    = APB_ADDR_W'(0);
  localparam logic [APB_ADDR_W-1:0] ADDR_STREAM_SEED = APB_ADDR_W'(8);
  localparam logic [63:0] ALL_ONES = '1;

  localparam int IDLE_LIMIT      = 3000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_CYCLES     = 250;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 255;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] skip_count;
  } request_t;

  typedef struct packed {
    logic [22:0] sample_zero;
    logic [22:0] sample_one;
    logic [22:0] sample_two;
    logic [22:0] sample_three;
  } sample_set_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  phx_req_if req_ch();
  phx_smp_if smp_ch();

  philox_uniform_generator dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .smp     (smp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  request_t    pending_requests[$];
  sample_set_t expected_samples[$];

  logic [127:0] block_counter_shadow = '0;
  logic [63:0]  key_shadow = '0;
  logic [63:0]  stream_shadow = '0;

  int errors = 0;
  int requests_taken = 0;
  int results_taken = 0;

  request_t    current_req = '0;
  bit          offering = 1'b0;
  int unsigned send_gap = 0;
  bit          taking = 1'b0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned stuck_cycles = 0;

  function automatic sample_set_t philox_samples(input logic [127:0] ctr,
                                                 input logic [63:0] key);
    logic [31:0] w0, w1, w2, w3, k0, k1;
    logic [63:0] prod0, prod2;
    sample_set_t s;
    int r;
    {w3, w2, w1, w0} = ctr;
    k0 = key[31:0];
    k1 = key[63:32];
    for (r = 0; r < PHILOX_ROUND_COUNT; r++) begin
      if (r > 0) begin
        k0 = k0 + KEY_STEP0;
        k1 = k1 + KEY_STEP1;
      end
      prod0 = 64'(MUL_LANE0) * 64'(w0);
      prod2 = 64'(MUL_LANE2) * 64'(w2);
      {w0, w1, w2, w3} = {prod2[63:32] ^ w1 ^ k0, prod2[31:0],
                          prod0[63:32] ^ w3 ^ k1, prod0[31:0]};
    end
    s.sample_zero  = w0[22:0];
    s.sample_one   = w1[22:0];
    s.sample_two   = w2[22:0];
    s.sample_three = w3[22:0];
    return s;
  endfunction

  task automatic advance_generator(input request_t rq);
    case (rq.kind)
      REQ_GEN: begin
        expected_samples.push_back(philox_samples(block_counter_shadow, key_shadow));
        block_counter_shadow = block_counter_shadow + 128'd1;
      end
      REQ_SKIP:    block_counter_shadow = block_counter_shadow + {64'd0, rq.skip_count};
      REQ_RESTART: block_counter_shadow = {stream_shadow, 64'd0};
      default: ;
    endcase
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] seed_value();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_request(input logic [1:0] kind, input logic [63:0] count);
    request_t rq;
    rq.kind = kind;
    rq.skip_count = count;
    pending_requests.push_back(rq);
  endtask

  task automatic queue_random_request();
    int unsigned pick;
    logic [1:0]  kind;
    logic [63:0] count;
    pick = $urandom_range(0, 99);
    if (pick < 72) kind = REQ_GEN;
    else if (pick < 86) kind = REQ_SKIP;
    else if (pick < 95) kind = REQ_RESTART;
    else kind = REQ_UNUSED;
    case ($urandom_range(0, 7))
      0: count = 64'($urandom_range(0, 15));
      1: count = ALL_ONES - 64'($urandom_range(0, 15));
      2: count = {32'd0, $urandom};
      default: count = {$urandom, $urandom};
    endcase
    queue_request(kind, count);
  endtask

  task automatic write_register(input logic [APB_ADDR_W-1:0] addr, input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_KEY_SEED) key_shadow = value;
    else stream_shadow = value;
  endtask

  // skip and restart leave no result behind, so let the block settle too
  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || offering || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [22:0] want,
                             input logic [22:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      offering = 1'b0;
      send_gap = 0;
      req_ch.valid <= 1'b0;
    end else begin
      if (offering && req_ch.ready) begin
        advance_generator(current_req);
        requests_taken++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_requests.size() != 0) begin
          current_req = pending_requests.pop_front();
          offering = 1'b1;
          send_gap = ((requests_taken / 128) % 5 == 4) ? 0 : idle_length();
        end
      end
      req_ch.valid      <= offering;
      req_ch.req_type   <= current_req.kind;
      req_ch.skip_count <= current_req.skip_count;
    end
  end

  // sample monitor
  always @(posedge clk) begin
    sample_set_t got;
    sample_set_t want;
    if (rst) begin
      taking = 1'b0;
      stall_left = 0;
      hold_left = 0;
      smp_ch.ready <= 1'b0;
    end else begin
      if (taking && smp_ch.valid) begin
        got.sample_zero  = smp_ch.sample_zero;
        got.sample_one   = smp_ch.sample_one;
        got.sample_two   = smp_ch.sample_two;
        got.sample_three = smp_ch.sample_three;
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected item, expected none actual %h", $time, got);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          check_field("sample_zero", want.sample_zero, got.sample_zero);
          check_field("sample_one", want.sample_one, got.sample_one);
          check_field("sample_two", want.sample_two, got.sample_two);
          check_field("sample_three", want.sample_three, got.sample_three);
        end
        results_taken++;
        // long back-pressure so the request side fills up and stalls
        if (results_taken % 500 == 40) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        taking = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        taking = 1'b0;
      end else begin
        taking = 1'b1;
        if ((results_taken / 64) % 4 != 3 && $urandom_range(0, 4) == 0)
          stall_left = idle_length();
      end
      smp_ch.ready <= taking;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles = 0;
    end else if ((req_ch.valid && req_ch.ready) || (smp_ch.valid && smp_ch.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles == IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_GEN;
    req_ch.skip_count = '0;
    smp_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset key and stream, counter carries out of the low half
    @(negedge clk);
    queue_request(REQ_GEN, 64'd0);
    queue_request(REQ_GEN, ALL_ONES);
    queue_request(REQ_SKIP, 64'd0);
    queue_request(REQ_SKIP, ALL_ONES);
    queue_request(REQ_GEN, 64'd0);
    queue_request(REQ_UNUSED, ALL_ONES);
    queue_request(REQ_GEN, 64'd0);
    queue_request(REQ_RESTART, ALL_ONES);
    queue_request(REQ_GEN, 64'd0);
    wait_until_idle();

    // all-ones seeds: counter reaches its top and wraps to zero
    write_register(ADDR_KEY_SEED, ALL_ONES);
    write_register(ADDR_STREAM_SEED, ALL_ONES);
    @(negedge clk);
    queue_request(REQ_RESTART, 64'd0);
    queue_request(REQ_SKIP, ALL_ONES);
    queue_request(REQ_GEN, 64'd0);
    queue_request(REQ_GEN, 64'd0);
    queue_request(REQ_SKIP, 64'h8000_0000_0000_0000);
    queue_request(REQ_SKIP, 64'h8000_0000_0000_0000);
    queue_request(REQ_GEN, 64'd0);
    queue_request(REQ_SKIP, 64'd1);
    queue_request(REQ_GEN, 64'd0);
    queue_request(REQ_UNUSED, 64'd0);
    queue_request(REQ_GEN, 64'd0);
    wait_until_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_register(ADDR_KEY_SEED, (p == 0) ? 64'd0 : seed_value());
      write_register(ADDR_STREAM_SEED, (p == 0) ? 64'd0 : seed_value());
      @(negedge clk);
      repeat (ITEMS_PER_PHASE) queue_random_request();
      wait_until_idle();
    end

    if (errors == 0 && expected_samples.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/phx_pkg.sv
rtl/phx_req_if.sv
rtl/phx_smp_if.sv
rtl/phx_cfg.sv
rtl/phx_ctrl.sv
rtl/phx_dp.sv
rtl/philox_uniform_generator.sv
bench/philox_uniform_generator_test.sv
